// ===== src/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5 package
// shared constants, types and round tables for the md5 digest engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int          NUM_ROUNDS = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_RUN,
    ST_FOLD,
    ST_EMIT
  } md5_state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_LEN,
    RET_EMIT
  } md5_ret_t;

  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       count_len;
    logic       put_len;
    logic       start_round;
    logic       do_round;
    logic       fold;
    logic       restart;
  } md5_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       pad_two;
    logic       last_round;
  } md5_stat_t;

  function automatic logic [31:0] add_const(input logic [5:0] r);
    logic [31:0] k;
    begin
      unique case (r)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
        6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
        6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
        6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    begin
      unique case ({r[5:4], r[1:0]})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

endpackage

// ===== src/md5_if.sv =====
// ----------------------------------------------------------------------------
// md5 channel interfaces
// valid/ready channels for message bytes and digest words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// ===== src/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// md5 datapath
// block buffer, length counter, round registers and chaining words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_datapath import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md5_cmd_t    cmd,
  output md5_stat_t   stat,
  input  logic [1:0]  out_sel,
  output logic [31:0] out_word
);

  logic [31:0] chain [4];
  logic [31:0] block [16];
  logic [63:0] bit_len;
  logic [31:0] va, vb, vc, vd;
  logic [5:0]  round;

  logic [5:0]  pos;
  logic [3:0]  g;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;

  assign pos = bit_len[8:3];
  assign stat.block_full = (pos == 6'd63);
  assign stat.pad_two = (pos >= 6'd56);
  assign stat.last_round = (round == 6'(NUM_ROUNDS - 1));
  assign out_word = chain[out_sel];

  always_comb begin
    unique case (round[5:4])
      2'd0: begin
        f = (vb & vc) | (~vb & vd);
        g = round[3:0];
      end
      2'd1: begin
        f = (vb & vd) | (vc & ~vd);
        g = 4'(5 * round[3:0] + 1);
      end
      2'd2: begin
        f = vb ^ vc ^ vd;
        g = 4'(3 * round[3:0] + 5);
      end
      default: begin
        f = vc ^ (vb | ~vd);
        g = 4'(7 * round[3:0]);
      end
    endcase
    sum = va + f + add_const(round) + block[g];
    sh  = rot_amount(round);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      chain[0] <= INIT_A;
      chain[1] <= INIT_B;
      chain[2] <= INIT_C;
      chain[3] <= INIT_D;
      for (int i = 0; i < 16; i++) block[i] <= '0;
      bit_len <= '0;
      round <= '0;
      if (rst) begin
        va <= '0; vb <= '0; vc <= '0; vd <= '0;
      end
    end else begin
      if (cmd.load_byte) begin
        block[pos[5:2]] <= block[pos[5:2]] | ({24'd0, cmd.byte_val} << {pos[1:0], 3'b000});
      end
      if (cmd.count_len) bit_len <= bit_len + 64'd8;
      if (cmd.put_len) begin
        block[14] <= bit_len[31:0];
        block[15] <= bit_len[63:32];
      end
      if (cmd.start_round) begin
        va <= chain[0]; vb <= chain[1]; vc <= chain[2]; vd <= chain[3];
        round <= '0;
      end
      if (cmd.do_round) begin
        va <= vd;
        vd <= vc;
        vc <= vb;
        vb <= vb + rot;
        round <= round + 6'd1;
      end
      if (cmd.fold) begin
        chain[0] <= chain[0] + va;
        chain[1] <= chain[1] + vb;
        chain[2] <= chain[2] + vc;
        chain[3] <= chain[3] + vd;
        for (int i = 0; i < 16; i++) block[i] <= '0;
        round <= '0;
      end
    end
  end

endmodule

// ===== src/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5 controller
// sequences byte loads, padding, compression and digest output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_ctrl import md5_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  md5_in_if.sink     in_ch,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] out_sel,
  output md5_cmd_t   cmd,
  input  md5_stat_t  stat
);

  md5_state_t state, state_next;
  md5_ret_t   ret, ret_next;
  logic [1:0] idx, idx_next;

  assign out_sel = idx;
  assign out_valid = (state == ST_EMIT);
  assign in_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= RET_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next = ret;
    idx_next = idx;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.byte_present) begin
            cmd.load_byte = 1'b1;
            cmd.byte_val = in_ch.data_byte;
            cmd.count_len = 1'b1;
            if (stat.block_full) begin
              cmd.start_round = 1'b1;
              state_next = ST_RUN;
              ret_next = in_ch.message_end ? RET_PAD : RET_IDLE;
            end else if (in_ch.message_end) begin
              state_next = ST_PAD;
            end
          end else if (in_ch.message_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.load_byte = 1'b1;
        cmd.byte_val = PAD_BYTE;
        cmd.start_round = stat.pad_two;
        state_next = stat.pad_two ? ST_RUN : ST_LEN;
        ret_next = RET_LEN;
      end
      ST_LEN: begin
        cmd.put_len = 1'b1;
        cmd.start_round = 1'b1;
        state_next = ST_RUN;
        ret_next = RET_EMIT;
      end
      ST_RUN: begin
        cmd.do_round = 1'b1;
        if (stat.last_round) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        idx_next = '0;
        unique case (ret)
          RET_PAD: state_next = ST_PAD;
          RET_LEN: state_next = ST_LEN;
          RET_EMIT: state_next = ST_EMIT;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_ready) begin
          idx_next = idx + 2'd1;
          if (idx == 2'd3) begin
            cmd.restart = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_run_ends_fold: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && stat.last_round |=> state == ST_FOLD)
    else $error("round loop overran");
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_FOLD && ret == RET_EMIT |=> state == ST_EMIT && idx == 2'd0)
    else $error("digest not started at word a");
`endif

endmodule

// ===== src/md5_digest_engine.sv =====
// a byte is taken while idle; a byte that fills a block starts a compression first
// message end: pad byte, a compression if the length no longer fits, length words
//   and a compression, then four digest words one per cycle while out_ready is high
// the round loop runs one md5 round per cycle, and no byte is taken while it runs
// synchronous reset loads the md5 initial chaining words and clears length
// ----------------------------------------------------------------------------
// md5 digest engine
// byte-serial md5 hash with one-round-per-cycle compression
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_digest_engine import md5_pkg::*; (
  input logic       clk,
  input logic       rst,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  md5_cmd_t    cmd;
  md5_stat_t   stat;
  logic [1:0]  sel;
  logic [31:0] word;

  md5_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ready(out_ch.ready),
    .out_valid(out_ch.valid), .out_sel(sel), .cmd(cmd), .stat(stat)
  );

  md5_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .out_sel(sel), .out_word(word)
  );

  assign out_ch.digest_word = word;
  assign out_ch.word_index = sel;
  assign out_ch.digest_last = (sel == 2'd3);

endmodule

// ===== tb/md5_digest_engine_tb.sv =====
// ----------------------------------------------------------------------------
// md5 digest engine testbench
// drives byte words into the engine, computes md5 digests in a local model
// and checks every digest word in order under random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class md5_digest_board;
  logic [31:0] chain[4];
  logic [31:0] blk[16];
  logic [63:0] nbits;
  logic [31:0] want_word[$];
  logic [1:0]  want_idx[$];
  logic        want_last[$];
  int          errors;
  int          digests;
  int          words_seen;

  function new();
    errors = 0;
    digests = 0;
    words_seen = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = md5_pkg::INIT_A;
    chain[1] = md5_pkg::INIT_B;
    chain[2] = md5_pkg::INIT_C;
    chain[3] = md5_pkg::INIT_D;
    foreach (blk[i]) blk[i] = '0;
    nbits = '0;
  endfunction

  function logic [31:0] rotl(logic [31:0] x, int n);
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function void compress();
    logic [31:0] a, b, c, d, f, t;
    logic [31:0] kt[64];
    int sh[16];
    int g;
    kt = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
           32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
           32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
           32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
           32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
           32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
           32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
           32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
           32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
           32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
           32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
           32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
           32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
           32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
           32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
           32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d); g = r;
      end else if (r < 32) begin
        f = (b & d) | (c & ~d); g = (5 * r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d; g = (3 * r + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * r) % 16;
      end
      t = d; d = c; c = b;
      b = b + rotl(a + f + kt[r] + blk[g], sh[(r / 16) * 4 + r % 4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    foreach (blk[i]) blk[i] = '0;
  endfunction

  function void put(int pos, logic [7:0] v);
    blk[pos / 4] |= 32'(v) << (8 * (pos % 4));
  endfunction

  function void note_word(logic [7:0] data, logic present, logic last);
    int pos;
    if (present) begin
      pos = nbits[8:3];
      put(pos, data);
      nbits += 8;
      if (pos == 63) compress();
    end
    if (!last) return;
    pos = nbits[8:3];
    put(pos, md5_pkg::PAD_BYTE);
    if (pos >= 56) compress();
    blk[14] = nbits[31:0];
    blk[15] = nbits[63:32];
    compress();
    for (int k = 0; k < 4; k++) begin
      want_word = {want_word, chain[k]};
      want_idx = {want_idx, 2'(k)};
      want_last = {want_last, (k == 3)};
    end
    digests++;
    restart();
  endfunction

  function void check_word(logic [31:0] w, logic [1:0] idx, logic last);
    words_seen++;
    if (want_word.size() == 0) begin
      $error("unexpected digest word %h", w);
      errors++;
      return;
    end
    if (w !== want_word[0]) begin
      $error("digest_word expected %h actual %h", want_word[0], w);
      errors++;
    end
    if (idx !== want_idx[0]) begin
      $error("word_index expected %0d actual %0d", want_idx[0], idx);
      errors++;
    end
    if (last !== want_last[0]) begin
      $error("digest_last expected %0d actual %0d", want_last[0], last);
      errors++;
    end
    void'(want_word.pop_front());
    void'(want_idx.pop_front());
    void'(want_last.pop_front());
  endfunction
endclass

module md5_digest_engine_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   sent = 0;

  md5_in_if  in_ch();
  md5_out_if out_ch();
  md5_digest_board board = new();

  md5_digest_engine dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.message_end = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_word(out_ch.digest_word, out_ch.word_index, out_ch.digest_last);
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(logic [7:0] data, logic present, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.byte_present <= present;
    in_ch.message_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_word(data, present, last);
    sent++;
  endtask

  task automatic send_message(int len, bit empty_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
    end
    if (empty_end || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.want_word.size() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty, single extremes, idle items, pad boundary lengths
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'ha5, 1'b1, 1'b0);
    send_word(8'h3c, 1'b0, 1'b1);
    send_message(3, 1'b0);
    drain();
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b1);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 13 : (ph == 1) ? 46 : 0;
      recv_idle = (ph == 0) ? 46 : (ph == 1) ? 13 : 0;
      while (sent < 85 * (ph + 1) + 190) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
        send_message(len, $urandom_range(3) == 0);
      end
      drain();
    end
    recv_idle = 0;
    repeat (150) @(posedge clk);
    $display("sent %0d words, %0d digests, %0d digest words checked",
             sent, board.digests, board.words_seen);
    if (board.errors == 0 && board.want_word.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
